@@ rtl/ocv_pkg.sv @@
`timescale 1ns / 1ps
package ocv_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        CFG_ANGLE_PER_COUNT = 3'd0,
        CFG_ORBIT_DISTANCE  = 3'd1,
        CFG_TARGET_X        = 3'd2,
        CFG_TARGET_Y        = 3'd3,
        CFG_TARGET_Z        = 3'd4,
        CFG_PITCH_UPPER     = 3'd5,
        CFG_PITCH_LOWER     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEL_POSITION  = 2'd0,
        SEL_VIEW      = 2'd1,
        SEL_BILLBOARD = 2'd2
    } t_sel;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd536870912;
            5'd1:  v = 34'sd316933406;
            5'd2:  v = 34'sd167458907;
            5'd3:  v = 34'sd85004756;
            5'd4:  v = 34'sd42667331;
            5'd5:  v = 34'sd21354465;
            5'd6:  v = 34'sd10679838;
            5'd7:  v = 34'sd5340245;
            5'd8:  v = 34'sd2670163;
            5'd9:  v = 34'sd1335087;
            5'd10: v = 34'sd667544;
            5'd11: v = 34'sd333772;
            5'd12: v = 34'sd166886;
            5'd13: v = 34'sd83443;
            5'd14: v = 34'sd41722;
            5'd15: v = 34'sd20861;
            5'd16: v = 34'sd10430;
            5'd17: v = 34'sd5215;
            5'd18: v = 34'sd2608;
            5'd19: v = 34'sd1304;
            5'd20: v = 34'sd652;
            5'd21: v = 34'sd326;
            5'd22: v = 34'sd163;
            5'd23: v = 34'sd81;
            5'd24: v = 34'sd41;
            5'd25: v = 34'sd20;
            5'd26: v = 34'sd10;
            5'd27: v = 34'sd5;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ocv_if.sv @@
`timescale 1ns / 1ps
interface ocv_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic               control_enabled;
    modport source(output valid, mouse_dx, mouse_dy, control_enabled, input ready);
    modport sink(input valid, mouse_dx, mouse_dy, control_enabled, output ready);
endinterface

interface ocv_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         matrix_select;
    logic [1:0]         row_number;
    logic signed [31:0] element_0;
    logic signed [31:0] element_1;
    logic signed [31:0] element_2;
    logic signed [31:0] element_3;
    logic               last_result;
    modport source(output valid, matrix_select, row_number, element_0, element_1,
                   element_2, element_3, last_result, input ready);
    modport sink(input valid, matrix_select, row_number, element_0, element_1,
                 element_2, element_3, last_result, output ready);
endinterface

@@ rtl/ocv_cordic.sv @@
`timescale 1ns / 1ps
module ocv_cordic import ocv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [31:0]        i_angle,
    output logic               o_done,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    logic signed [33:0] r_x, r_y, r_z;
    logic [4:0]         r_i;
    logic               r_busy, r_flip, r_done;
    logic signed [33:0] w_z0, w_dx, w_dy, w_sy, w_cx;

    assign w_z0 = $signed({{2{i_angle[31]}}, i_angle});
    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_sy = r_flip ? -r_y : r_y;
    assign w_cx = r_flip ? -r_x : r_x;
    assign o_sin  = w_sy[31:0];
    assign o_cos  = w_cx[31:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_i    <= '0;
                r_busy <= 1'b1;
                if (w_z0 > 34'sd1073741824) begin
                    r_z    <= w_z0 - 34'sd2147483648;
                    r_flip <= 1'b1;
                end else if (w_z0 < -34'sd1073741824) begin
                    r_z    <= w_z0 + 34'sd2147483648;
                    r_flip <= 1'b1;
                end else begin
                    r_z    <= w_z0;
                    r_flip <= 1'b0;
                end
            end else if (r_busy) begin
                if (!r_z[33]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - atan_q30(r_i);
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + atan_q30(r_i);
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/ocv_smul.sv @@
`timescale 1ns / 1ps
module ocv_smul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic               o_done,
    output logic signed [65:0] o_prod
);
    logic signed [32:0] r_a;
    logic [33:0]        r_hi;
    logic [32:0]        r_lo;
    logic [5:0]         r_cnt;
    logic               r_busy, r_done;
    logic signed [33:0] w_add, w_sum;
    logic [66:0]        w_full;

    always_comb begin
        if (!r_lo[0]) begin
            w_add = '0;
        end else if (r_cnt == 6'd32) begin
            w_add = -$signed({r_a[32], r_a});
        end else begin
            w_add = $signed({r_a[32], r_a});
        end
        w_sum = $signed(r_hi) + w_add;
    end

    assign w_full = {r_hi, r_lo};
    assign o_prod = $signed(w_full[65:0]);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= {w_sum[33], w_sum[33:1]};
                r_lo  <= {w_sum[0], r_lo[32:1]};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ rtl/orbit_camera_view_update.sv @@
`timescale 1ns / 1ps
// Orbit camera view update.
// i_in takes one mouse beat (dx, dy, control enable). When enabled, yaw and
// pitch take the scaled deltas; pitch is clamped to the limit registers.
// o_out then sends nine beats: camera position, four view matrix rows and
// four billboard rows, the ninth flagged by last_result.
// Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must make them only while idle, as the block itself does not enforce it.
// One item at a time: i_in.ready is high only when no item is in flight.
// An item passes a yaw update and a pitch update (skipped with control
// disabled), two 30-step CORDIC runs, then 15 products through a bit-serial
// multiplier. The nine output beats follow at one per cycle when the
// receiver is ready; a stall holds the current beat.
// Reset restores register defaults, yaw 0 and pitch -0.3 rad.
module orbit_camera_view_update import ocv_pkg::*; #(
    parameter int FRACTION_BITS = 16,
    parameter int ANGLE_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    ocv_in_if.sink      i_in,
    ocv_out_if.source   o_out
);
    localparam int OUT_SHIFT = 30 - FRACTION_BITS;
    localparam logic signed [31:0] PITCH_RESET = -32'sd205069583;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_UPD_X, S_UPD_P, S_CP_GO, S_CP_WAIT, S_CY_GO, S_CY_WAIT,
        S_MUL_GO, S_MUL_WAIT, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_CP_SY, OP_CP_CY, OP_SP_SY, OP_SP_CY, OP_F0_D, OP_SP_D, OP_F2_D,
        OP_R0_P0, OP_R2_P2, OP_U0_P0, OP_U1_P1, OP_U2_P2, OP_F0_P0, OP_F1_P1,
        OP_F2_P2
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [3:0] r_beat;

    logic [27:0]        r_apc;
    logic [30:0]        r_dist;
    logic signed [31:0] r_tx, r_ty, r_tz, r_pup, r_plo;
    logic [ANGLE_BITS-1:0] r_yaw, r_pitch;
    logic signed [15:0] r_dx, r_dy;

    logic signed [31:0] r_sp, r_cp, r_sy, r_cy, r_f0, r_f2, r_u0, r_u2;
    logic signed [31:0] r_p0, r_p1, r_p2, r_t0, r_t1, r_t2;
    logic signed [67:0] r_acc;

    logic               w_cor_start, w_cor_done, w_mul_start, w_mul_done;
    logic [31:0]        w_angle;
    logic signed [31:0] w_sin, w_cos;
    logic signed [32:0] w_a, w_b;
    logic signed [65:0] w_prod, w_rs;
    logic signed [67:0] w_acc_n, w_tr;
    logic signed [44:0] w_mx;
    logic signed [45:0] w_pa, w_pa_c;
    logic signed [28:0] w_step;
    logic signed [31:0] w_r0, w_r2, w_u1, w_f1, w_rs32, w_rsn;
    logic               w_sgn, w_first, w_last;

    function automatic logic signed [32:0] x33(input logic signed [31:0] v);
        return $signed({v[31], v});
    endfunction

    function automatic logic signed [67:0] x68(input logic signed [31:0] v);
        return $signed({{36{v[31]}}, v});
    endfunction

    function automatic logic signed [31:0] q_out(input logic signed [31:0] v);
        logic signed [67:0] t;
        t = x68(v) + (68'sd1 <<< (OUT_SHIFT - 1));
        return sat32(t >>> OUT_SHIFT);
    endfunction

    assign w_sgn = r_cp[31];
    assign w_r0  = w_sgn ? -r_cy : r_cy;
    assign w_r2  = w_sgn ? r_sy : -r_sy;
    assign w_u1  = w_sgn ? -r_cp : r_cp;
    assign w_f1  = -r_sp;

    assign w_step = $signed({1'b0, r_apc});
    assign w_mx   = (r_state == S_UPD_X ? r_dx : r_dy) * w_step;
    assign w_pa   = $signed({{(46 - ANGLE_BITS){r_pitch[ANGLE_BITS-1]}}, r_pitch}) + w_mx;

    always_comb begin
        w_pa_c = w_pa;
        if (w_pa_c > $signed({{14{r_pup[31]}}, r_pup})) begin
            w_pa_c = $signed({{14{r_pup[31]}}, r_pup});
        end
        if (w_pa_c < $signed({{14{r_plo[31]}}, r_plo})) begin
            w_pa_c = $signed({{14{r_plo[31]}}, r_plo});
        end
    end

    assign w_cor_start = (r_state == S_CP_GO) || (r_state == S_CY_GO);
    assign w_angle = (r_state == S_CP_GO) ? (32'(r_pitch) << (32 - ANGLE_BITS))
                                          : (32'(r_yaw) << (32 - ANGLE_BITS));

    ocv_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_angle (w_angle),
        .o_done  (w_cor_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    always_comb begin
        w_first = 1'b0;
        w_last  = 1'b0;
        case (r_op)
            OP_CP_SY: begin w_a = x33(r_cp); w_b = x33(r_sy); end
            OP_CP_CY: begin w_a = x33(r_cp); w_b = x33(r_cy); end
            OP_SP_SY: begin w_a = x33(r_sp); w_b = x33(r_sy); end
            OP_SP_CY: begin w_a = x33(r_sp); w_b = x33(r_cy); end
            OP_F0_D:  begin w_a = x33(r_f0); w_b = $signed({2'b00, r_dist}); end
            OP_SP_D:  begin w_a = x33(r_sp); w_b = $signed({2'b00, r_dist}); end
            OP_F2_D:  begin w_a = x33(r_f2); w_b = $signed({2'b00, r_dist}); end
            OP_R0_P0: begin w_a = x33(w_r0); w_b = x33(r_p0); w_first = 1'b1; end
            OP_R2_P2: begin w_a = x33(w_r2); w_b = x33(r_p2); w_last = 1'b1; end
            OP_U0_P0: begin w_a = x33(r_u0); w_b = x33(r_p0); w_first = 1'b1; end
            OP_U1_P1: begin w_a = x33(w_u1); w_b = x33(r_p1); end
            OP_U2_P2: begin w_a = x33(r_u2); w_b = x33(r_p2); w_last = 1'b1; end
            OP_F0_P0: begin w_a = x33(r_f0); w_b = x33(r_p0); w_first = 1'b1; end
            OP_F1_P1: begin w_a = x33(w_f1); w_b = x33(r_p1); end
            OP_F2_P2: begin w_a = x33(r_f2); w_b = x33(r_p2); w_last = 1'b1; end
            default:  begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_mul_start = (r_state == S_MUL_GO);

    ocv_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_rs    = (w_prod + (66'sd1 <<< 29)) >>> 30;
    assign w_rs32  = w_rs[31:0];
    assign w_rsn   = w_sgn ? -w_rs32 : w_rs32;
    assign w_acc_n = (w_first ? 68'sd0 : r_acc) + $signed({{2{w_prod[65]}}, w_prod});
    assign w_tr    = (-w_acc_n + (68'sd1 <<< 29)) >>> 30;

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        o_out.valid       = (r_state == S_OUT);
        o_out.last_result = 1'b0;
        o_out.element_3   = '0;
        case (r_beat)
            4'd0: begin
                o_out.matrix_select = SEL_POSITION; o_out.row_number = 2'd0;
                o_out.element_0 = r_p0; o_out.element_1 = r_p1; o_out.element_2 = r_p2;
            end
            4'd1: begin
                o_out.matrix_select = SEL_VIEW; o_out.row_number = 2'd0;
                o_out.element_0 = q_out(w_r0); o_out.element_1 = q_out(r_u0);
                o_out.element_2 = q_out(r_f0);
            end
            4'd2: begin
                o_out.matrix_select = SEL_VIEW; o_out.row_number = 2'd1;
                o_out.element_0 = '0; o_out.element_1 = q_out(w_u1);
                o_out.element_2 = q_out(w_f1);
            end
            4'd3: begin
                o_out.matrix_select = SEL_VIEW; o_out.row_number = 2'd2;
                o_out.element_0 = q_out(w_r2); o_out.element_1 = q_out(r_u2);
                o_out.element_2 = q_out(r_f2);
            end
            4'd4: begin
                o_out.matrix_select = SEL_VIEW; o_out.row_number = 2'd3;
                o_out.element_0 = r_t0; o_out.element_1 = r_t1; o_out.element_2 = r_t2;
                o_out.element_3 = ONE;
            end
            4'd5: begin
                o_out.matrix_select = SEL_BILLBOARD; o_out.row_number = 2'd0;
                o_out.element_0 = q_out(w_r0); o_out.element_1 = '0;
                o_out.element_2 = q_out(w_r2);
            end
            4'd6: begin
                o_out.matrix_select = SEL_BILLBOARD; o_out.row_number = 2'd1;
                o_out.element_0 = q_out(r_u0); o_out.element_1 = q_out(w_u1);
                o_out.element_2 = q_out(r_u2);
            end
            4'd7: begin
                o_out.matrix_select = SEL_BILLBOARD; o_out.row_number = 2'd2;
                o_out.element_0 = q_out(r_f0); o_out.element_1 = q_out(w_f1);
                o_out.element_2 = q_out(r_f2);
            end
            default: begin
                o_out.matrix_select = SEL_BILLBOARD; o_out.row_number = 2'd3;
                o_out.element_0 = '0; o_out.element_1 = '0; o_out.element_2 = '0;
                o_out.element_3 = ONE; o_out.last_result = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CP_SY;
            r_beat  <= '0;
            r_apc   <= 28'd3417826;
            r_dist  <= 31'd983040;
            r_tx    <= '0;
            r_ty    <= '0;
            r_tz    <= '0;
            r_pup   <= 32'sd1061811359;
            r_plo   <= 32'sd59652324;
            r_yaw   <= '0;
            r_pitch <= PITCH_RESET[ANGLE_BITS-1:0];
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ANGLE_PER_COUNT: r_apc  <= i_cfg_data[27:0];
                    CFG_ORBIT_DISTANCE:  r_dist <= i_cfg_data[30:0];
                    CFG_TARGET_X:        r_tx   <= i_cfg_data;
                    CFG_TARGET_Y:        r_ty   <= i_cfg_data;
                    CFG_TARGET_Z:        r_tz   <= i_cfg_data;
                    CFG_PITCH_UPPER:     r_pup  <= i_cfg_data;
                    CFG_PITCH_LOWER:     r_plo  <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_dx    <= i_in.mouse_dx;
                        r_dy    <= i_in.mouse_dy;
                        r_state <= i_in.control_enabled ? S_UPD_X : S_CP_GO;
                    end
                end
                S_UPD_X: begin
                    r_yaw   <= r_yaw + w_mx[ANGLE_BITS-1:0];
                    r_state <= S_UPD_P;
                end
                S_UPD_P: begin
                    r_pitch <= w_pa_c[ANGLE_BITS-1:0];
                    r_state <= S_CP_GO;
                end
                S_CP_GO: r_state <= S_CP_WAIT;
                S_CP_WAIT: begin
                    if (w_cor_done) begin
                        r_sp    <= w_sin;
                        r_cp    <= w_cos;
                        r_state <= S_CY_GO;
                    end
                end
                S_CY_GO: r_state <= S_CY_WAIT;
                S_CY_WAIT: begin
                    if (w_cor_done) begin
                        r_sy    <= w_sin;
                        r_cy    <= w_cos;
                        r_op    <= OP_CP_SY;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO: r_state <= S_MUL_WAIT;
                S_MUL_WAIT: begin
                    if (w_mul_done) begin
                        r_acc <= w_acc_n;
                        case (r_op)
                            OP_CP_SY: r_f0 <= w_rs32;
                            OP_CP_CY: r_f2 <= w_rs32;
                            OP_SP_SY: r_u0 <= w_rsn;
                            OP_SP_CY: r_u2 <= w_rsn;
                            OP_F0_D:  r_p0 <= sat32(x68(r_tx) - $signed({{2{w_rs[65]}}, w_rs}));
                            OP_SP_D:  r_p1 <= sat32(x68(r_ty) + $signed({{2{w_rs[65]}}, w_rs}));
                            OP_F2_D:  r_p2 <= sat32(x68(r_tz) - $signed({{2{w_rs[65]}}, w_rs}));
                            OP_R2_P2: r_t0 <= sat32(w_tr);
                            OP_U2_P2: r_t1 <= sat32(w_tr);
                            OP_F2_P2: r_t2 <= sat32(w_tr);
                            default: ;
                        endcase
                        if (w_last && r_op == OP_F2_P2) begin
                            r_beat  <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_op    <= t_op'(r_op + 4'd1);
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        if (r_beat == 4'd8) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_beat <= r_beat + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
